### rtl/core/lbpw_pkg.sv
// Shared constants, types and register indexes for the lattice bilinear point warp.
// No dependencies; every other file but lbpw_ram refers to it by scoped names.
package lbpw_pkg;

   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_ROWS_DEF = 32;

   // signed width of a distance past the grid edge, holds p + cols*bw/2 for 64 boxes
   localparam int DX_W   = 40;
   localparam int FRAC_W = 17;
   localparam int ONE_Q16 = 65536;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_W     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_H     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_W     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_H     = 3'd5;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_WARP = 1'b1;

   // word carried through the front stages (loads need their payload at the write stage)
   typedef struct packed {
      logic               warp;
      logic [10:0]        vidx;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } item_type;

endpackage

### rtl/core/lbpw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbpw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1089
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/lbpw_locate.sv
// One axis of the box search: edge distance, box index, clamped ratio and outside offset.
// Seven register stages driven by the top level's stage enables; uses lbpw_pkg.
module lbpw_locate #(
   parameter int MAX_N = lbpw_pkg::MAX_COLS_DEF
) (
   input  logic                            clock,
   input  logic [7:1]                      en,
   input  logic signed [31:0]              p,
   input  logic [$clog2(MAX_N+1)-1:0]      n,
   input  logic [30:0]                     bw,
   input  logic [31:0]                     inv,
   output logic [$clog2(MAX_N+1)-1:0]      box3,
   output logic [lbpw_pkg::FRAC_W-1:0]     frac7,
   output logic signed [lbpw_pkg::DX_W-1:0] off7
);

   localparam int CW       = $clog2(MAX_N + 1);
   localparam int DXW      = lbpw_pkg::DX_W;
   localparam int HIW      = DXW - 33;
   localparam int FRAC_W_L = lbpw_pkg::FRAC_W;

   logic signed [DXW-1:0] dx1_ff, dx2_ff, dx3_ff, dx4_ff, r5_ff, r6_ff;
   logic signed [DXW-1:0] dx1_in, r5_in, off7_in;
   logic [CW+30:0]        nb;
   logic [HIW+31:0]       phi2_ff, phi2_in;
   logic [63:0]           plo2_ff, plo2_in;
   logic                  pos2_ff;
   logic [HIW+32:0]       q3;
   logic [CW-1:0]         nm1, b3_ff, b3_in;
   logic [CW+30:0]        bb4_ff, bb4_in;
   logic                  lo6_ff, hi6_ff;
   logic [63:0]           prod6_ff, prod6_in;
   logic [47:0]           fq;
   logic [FRAC_W_L-1:0]   frac7_ff, frac7_in;
   logic signed [DXW-1:0] off7_ff;

   always_comb begin
      nb      = (CW+31)'(n) * (CW+31)'(bw);
      dx1_in  = $signed(DXW'(p)) + $signed(DXW'(nb >> 1));
      phi2_in = (HIW+32)'(dx1_ff[DXW-2:32]) * (HIW+32)'(inv);
      plo2_in = 64'(dx1_ff[31:0]) * 64'(inv);
      q3      = (HIW+33)'(phi2_ff) + (HIW+33)'(plo2_ff[63:32]);
      nm1     = n - CW'(1);
      if (!pos2_ff) begin
         b3_in = '0;
      end else if (q3 > (HIW+33)'(nm1)) begin
         b3_in = nm1;
      end else begin
         b3_in = CW'(q3);
      end
      bb4_in   = (CW+31)'(b3_ff) * (CW+31)'(bw);
      r5_in    = dx4_ff - $signed(DXW'(bb4_ff));
      prod6_in = 64'(r5_ff[30:0]) * 64'(inv);
      fq       = prod6_ff[63:16];
      if (lo6_ff) begin
         frac7_in = '0;
         off7_in  = r6_ff;
      end else if (hi6_ff) begin
         frac7_in = FRAC_W_L'(lbpw_pkg::ONE_Q16);
         off7_in  = r6_ff - $signed(DXW'(bw));
      end else begin
         frac7_in = (fq > 48'(lbpw_pkg::ONE_Q16)) ? FRAC_W_L'(lbpw_pkg::ONE_Q16)
                                                  : FRAC_W_L'(fq);
         off7_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx1_ff <= dx1_in;
      end
      if (en[2]) begin
         dx2_ff  <= dx1_ff;
         pos2_ff <= dx1_ff > 0;
         phi2_ff <= phi2_in;
         plo2_ff <= plo2_in;
      end
      if (en[3]) begin
         dx3_ff <= dx2_ff;
         b3_ff  <= b3_in;
      end
      if (en[4]) begin
         dx4_ff <= dx3_ff;
         bb4_ff <= bb4_in;
      end
      if (en[5]) begin
         r5_ff <= r5_in;
      end
      if (en[6]) begin
         r6_ff    <= r5_ff;
         lo6_ff   <= r5_ff <= 0;
         hi6_ff   <= r5_ff >= $signed(DXW'(bw));
         prod6_ff <= prod6_in;
      end
      if (en[7]) begin
         frac7_ff <= frac7_in;
         off7_ff  <= off7_in;
      end
   end

   assign box3  = b3_ff;
   assign frac7 = frac7_ff;
   assign off7  = off7_ff;

endmodule

### rtl/core/lbpw_lerp.sv
// Two-stage rounded interpolation a + floor(((b-a)*f + 2^15) / 2^16), f in Q16 0..1.
// Uses lbpw_pkg for the ratio width.
module lbpw_lerp #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          en_prod,
   input  logic                          en_res,
   input  logic signed [W-1:0]           a,
   input  logic signed [W-1:0]           b,
   input  logic [lbpw_pkg::FRAC_W-1:0]   f,
   output logic signed [W-1:0]           result
);

   localparam int PW = W + lbpw_pkg::FRAC_W + 2;

   logic signed [W:0]    diff;
   logic signed [PW-1:0] prod_in, prod_ff, rnd;
   logic signed [W-1:0]  a_ff, res_ff;

   always_comb begin
      diff    = $signed((W+1)'(b)) - $signed((W+1)'(a));
      prod_in = PW'(diff) * PW'($signed({1'b0, f}));
      rnd     = (prod_ff + PW'(32768)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (en_prod) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (en_res) begin
         res_ff <= a_ff + W'(rnd);
      end
   end

   assign result = res_ff;

endmodule

### rtl/core/lattice_bilinear_point_warp.sv
// Top level of the lattice bilinear point warp: registers, stage control, lattice store.
// Uses lbpw_pkg, lbpw_ram, lbpw_locate and lbpw_lerp.
//
//   port group  | dir    | carries
//   req_*       | in     | load or warp word: action, vertex_index, point_x, point_y
//   rsp_*       | out    | warped_x, warped_y, one word per warp, none per load
//   csr_*       | in     | register writes, index 0..5, no read-back
//
// Twelve register stages; one word may enter every cycle when the output is not held, and
// a warp result leaves from the last of them. The stage count is set by the four
// multiplier levels of the box search and the two levels of interpolation.
// Reset is synchronous and clears valid bits and configuration registers; the lattice is not cleared.
// Each stage moves when the stage after it is empty or moving, so a held output stalls
// only the stages behind it and bubbles close up.
module lattice_bilinear_point_warp #(
   parameter int MAX_COLS = lbpw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lbpw_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [10:0]                       req_vertex_index,
   input  logic signed [31:0]                req_point_x,
   input  logic signed [31:0]                req_point_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_warped_x,
   output logic signed [31:0]                rsp_warped_y,
   input  logic                              csr_write_en,
   input  logic [lbpw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);

   localparam int NS    = 12;
   localparam int CWC   = $clog2(MAX_COLS + 1);
   localparam int CWR   = $clog2(MAX_ROWS + 1);
   localparam int DEPTH = (MAX_COLS + 1) * (MAX_ROWS + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int DXW   = lbpw_pkg::DX_W;
   localparam int FW    = lbpw_pkg::FRAC_W;
   localparam int SW    = DXW + 1;

   // ---------------- configuration registers ----------------
   logic [5:0]  grid_cols_ff, grid_rows_ff;
   logic [30:0] box_w_ff, box_h_ff;
   logic [31:0] inv_w_ff, inv_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= 6'd1;
         grid_rows_ff <= 6'd1;
         box_w_ff     <= 31'd65536;
         box_h_ff     <= 31'd65536;
         inv_w_ff     <= 32'd65536;
         inv_h_ff     <= 32'd65536;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lbpw_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata[5:0];
            lbpw_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[5:0];
            lbpw_pkg::CSR_BOX_W:     box_w_ff     <= csr_wdata[30:0];
            lbpw_pkg::CSR_BOX_H:     box_h_ff     <= csr_wdata[30:0];
            lbpw_pkg::CSR_INV_W:     inv_w_ff     <= csr_wdata;
            lbpw_pkg::CSR_INV_H:     inv_h_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective counts: zero acts as one, anything above the maximum acts as the maximum
   logic [CWC-1:0] cols_eff;
   logic [CWR-1:0] rows_eff;
   logic [CWC:0]   stride;

   always_comb begin
      if (grid_cols_ff == '0) begin
         cols_eff = CWC'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = CWC'(MAX_COLS);
      end else begin
         cols_eff = CWC'(grid_cols_ff);
      end
      if (grid_rows_ff == '0) begin
         rows_eff = CWR'(1);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = CWR'(MAX_ROWS);
      end else begin
         rows_eff = CWR'(grid_rows_ff);
      end
      stride = (CWC+1)'(cols_eff) + (CWC+1)'(1);
   end

   // ---------------- stage control ----------------
   logic [NS:1] v_ff, v_in, en;
   lbpw_pkg::item_type item_ff [1:5];
   lbpw_pkg::item_type item_in;

   always_comb begin
      en[NS] = !v_ff[NS] || rsp_ready;
      for (int k = NS - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[1] = req_valid;
      for (int k = 2; k <= NS; k++) begin
         v_in[k] = v_ff[k-1];
      end
      // a load ends at the write stage
      v_in[6] = v_ff[5] && (item_ff[5].warp == lbpw_pkg::ACT_WARP);
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign item_in = '{warp: req_action, vidx: req_vertex_index,
                      px: req_point_x, py: req_point_y};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         item_ff[1] <= item_in;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   // ---------------- box search, one unit per axis ----------------
   logic [CWC-1:0]        bx3;
   logic [CWR-1:0]        by3;
   logic [FW-1:0]         t7, s7;
   logic signed [DXW-1:0] xoff7, yoff7;

   lbpw_locate #(.MAX_N(MAX_COLS)) u_loc_x (
      .clock(clock), .en(en[7:1]), .p(req_point_x), .n(cols_eff),
      .bw(box_w_ff), .inv(inv_w_ff), .box3(bx3), .frac7(t7), .off7(xoff7)
   );

   lbpw_locate #(.MAX_N(MAX_ROWS)) u_loc_y (
      .clock(clock), .en(en[7:1]), .p(req_point_y), .n(rows_eff),
      .bw(box_h_ff), .inv(inv_h_ff), .box3(by3), .frac7(s7), .off7(yoff7)
   );

   // ---------------- corner addresses ----------------
   logic [AW:0]   rowprod4_ff, rowprod4_in;
   logic [CWC-1:0] bx4_ff;
   logic [AW:0]   base5;
   logic [AW-1:0] addr5_ff [4];

   assign rowprod4_in = (AW+1)'(by3) * (AW+1)'(stride);
   assign base5       = rowprod4_ff + (AW+1)'(bx4_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rowprod4_ff <= rowprod4_in;
         bx4_ff      <= bx3;
      end
      if (en[5]) begin
         addr5_ff[0] <= AW'(base5);                                 // lower left
         addr5_ff[1] <= AW'(base5 + (AW+1)'(1));                    // lower right
         addr5_ff[2] <= AW'(base5 + (AW+1)'(stride) + (AW+1)'(1));  // upper right
         addr5_ff[3] <= AW'(base5 + (AW+1)'(stride));               // upper left
      end
   end

   // ---------------- lattice store: four copies, one per corner ----------------
   // a load writes at the same stage edge where a warp reads, so program order holds
   logic [31:0]   vidx_ext;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [63:0]   ram_wdata;
   logic [63:0]   ram_rdata [4];

   assign vidx_ext  = 32'(item_ff[5].vidx);
   assign ram_we    = en[6] && v_ff[5] && (item_ff[5].warp == lbpw_pkg::ACT_LOAD)
                      && (vidx_ext < 32'(DEPTH));
   assign ram_waddr = vidx_ext[AW-1:0];
   assign ram_wdata = {item_ff[5].py, item_ff[5].px};

   for (genvar g = 0; g < 4; g++) begin : g_corner
      lbpw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
         .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
         .re(en[6]), .raddr(addr5_ff[g]), .rdata(ram_rdata[g])
      );
   end

   logic signed [31:0] cx7_ff [4];
   logic signed [31:0] cy7_ff [4];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int c = 0; c < 4; c++) begin
            cx7_ff[c] <= ram_rdata[c][31:0];
            cy7_ff[c] <= ram_rdata[c][63:32];
         end
      end
   end

   // ---------------- interpolation ----------------
   // x: lerp(lerp(c1,c2,t), lerp(c4,c3,t), s); y: lerp(lerp(c1,c4,s), lerp(c2,c3,s), t)
   logic [FW-1:0]         t8_ff, s8_ff, t9_ff, s9_ff;
   logic signed [DXW-1:0] xoff_ff [8:11];
   logic signed [DXW-1:0] yoff_ff [8:11];
   logic signed [31:0]    lx0, lx1, ly0, ly1, wx11, wy11;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         t8_ff      <= t7;
         s8_ff      <= s7;
         xoff_ff[8] <= xoff7;
         yoff_ff[8] <= yoff7;
      end
      if (en[9]) begin
         t9_ff <= t8_ff;
         s9_ff <= s8_ff;
      end
      for (int k = 9; k <= 11; k++) begin
         if (en[k]) begin
            xoff_ff[k] <= xoff_ff[k-1];
            yoff_ff[k] <= yoff_ff[k-1];
         end
      end
   end

   lbpw_lerp #(.W(32)) u_lx0 (.clock(clock), .en_prod(en[8]), .en_res(en[9]),
      .a(cx7_ff[0]), .b(cx7_ff[1]), .f(t7), .result(lx0));
   lbpw_lerp #(.W(32)) u_lx1 (.clock(clock), .en_prod(en[8]), .en_res(en[9]),
      .a(cx7_ff[3]), .b(cx7_ff[2]), .f(t7), .result(lx1));
   lbpw_lerp #(.W(32)) u_ly0 (.clock(clock), .en_prod(en[8]), .en_res(en[9]),
      .a(cy7_ff[0]), .b(cy7_ff[3]), .f(s7), .result(ly0));
   lbpw_lerp #(.W(32)) u_ly1 (.clock(clock), .en_prod(en[8]), .en_res(en[9]),
      .a(cy7_ff[1]), .b(cy7_ff[2]), .f(s7), .result(ly1));

   lbpw_lerp #(.W(32)) u_wx (.clock(clock), .en_prod(en[10]), .en_res(en[11]),
      .a(lx0), .b(lx1), .f(s9_ff), .result(wx11));
   lbpw_lerp #(.W(32)) u_wy (.clock(clock), .en_prod(en[10]), .en_res(en[11]),
      .a(ly0), .b(ly1), .f(t9_ff), .result(wy11));

   // ---------------- outside offset, saturation, output word ----------------
   logic signed [SW-1:0] sum_x, sum_y;
   logic signed [31:0]   out_x_in, out_y_in, out_x_ff, out_y_ff;

   always_comb begin
      sum_x = SW'(wx11) + SW'(xoff_ff[11]);
      sum_y = SW'(wy11) + SW'(yoff_ff[11]);
      if (sum_x > SW'(32'sh7FFFFFFF)) begin
         out_x_in = 32'sh7FFFFFFF;
      end else if (sum_x < SW'(-64'sd2147483648)) begin
         out_x_in = 32'sh80000000;
      end else begin
         out_x_in = 32'(sum_x);
      end
      if (sum_y > SW'(32'sh7FFFFFFF)) begin
         out_y_in = 32'sh7FFFFFFF;
      end else if (sum_y < SW'(-64'sd2147483648)) begin
         out_y_in = 32'sh80000000;
      end else begin
         out_y_in = 32'(sum_y);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign rsp_valid    = v_ff[NS];
   assign rsp_warped_x = out_x_ff;
   assign rsp_warped_y = out_y_ff;

   // ---------------- assertions ----------------
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff && !rsp_ready) |-> !req_ready)
      else $error("full pipeline took a word under output stall");

   a_load_drops: assert property (@(posedge clock) disable iff (reset)
      (en[6] && v_ff[5] && item_ff[5].warp == lbpw_pkg::ACT_LOAD) |=> !v_ff[6])
      else $error("load word passed the write stage");

   a_we_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < 32'(DEPTH)))
      else $error("lattice write beyond the store");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[7] |-> (32'(t7) <= 32'(lbpw_pkg::ONE_Q16) && 32'(s7) <= 32'(lbpw_pkg::ONE_Q16)))
      else $error("cell ratio above one");

endmodule

### dv/lattice_bilinear_point_warp_test.sv
// Self-checking test of lattice_bilinear_point_warp: loads control points, warps query
// points and checks every result against an in-bench bilinear predictor. Needs lbpw_pkg.
`timescale 1ns / 1ps

module lattice_bilinear_point_warp_test;

   localparam int LAT_DEPTH = (lbpw_pkg::MAX_COLS_DEF + 1) * (lbpw_pkg::MAX_ROWS_DEF + 1);
   localparam int DRAIN_CYCLES = 20;   // pipeline is 12 stages deep

   typedef struct {
      logic signed [31:0] wx;
      logic signed [31:0] wy;
   } warp_word_type;

   // Warp predictor plus queue of pending results.
   class warp_scoreboard;
      bit [31:0]     lat_x [LAT_DEPTH];
      bit [31:0]     lat_y [LAT_DEPTH];
      bit [5:0]      cols_r, rows_r;
      bit [30:0]     bw_r, bh_r;
      bit [31:0]     inv_w_r, inv_h_r;
      warp_word_type pending_warps [$];
      int            errors;

      function new();
         cols_r = 1; rows_r = 1;
         bw_r = 65536; bh_r = 65536;
         inv_w_r = 65536; inv_h_r = 65536;
         errors = 0;
      endfunction

      function void set_reg(logic [lbpw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            lbpw_pkg::CSR_GRID_COLS: cols_r = val[5:0];
            lbpw_pkg::CSR_GRID_ROWS: rows_r = val[5:0];
            lbpw_pkg::CSR_BOX_W:     bw_r = val[30:0];
            lbpw_pkg::CSR_BOX_H:     bh_r = val[30:0];
            lbpw_pkg::CSR_INV_W:     inv_w_r = val;
            lbpw_pkg::CSR_INV_H:     inv_h_r = val;
            default: ;
         endcase
      endfunction

      function longint eff_count(longint n, longint maxv);
         if (n < 1) return 1;
         return (n > maxv) ? maxv : n;
      endfunction

      function longint blend(longint a, longint b, longint f);
         return a + (((b - a) * f + 32768) >>> 16);
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // box index, clamped ratio and the distance beyond the edge along one axis
      function void find_box(longint p, longint n, longint bw, longint inv,
                             output longint box, output longint frac, output longint off);
         longint    dx, r;
         bit [63:0] ud, q, uinv, fr;
         uinv = inv;
         dx = p + ((n * bw) >>> 1);
         box = 0;
         if (dx > 0) begin
            ud = dx;
            q = (ud >> 32) * uinv + (((ud & 64'hFFFF_FFFF) * uinv) >> 32);
            box = (q > n - 1) ? n - 1 : longint'(q);
         end
         r = dx - box * bw;
         if (r <= 0) begin
            frac = 0; off = r;
         end else if (r >= bw) begin
            frac = lbpw_pkg::ONE_Q16; off = r - bw;
         end else begin
            fr = (64'(r) * uinv) >> 16;
            frac = (fr > lbpw_pkg::ONE_Q16) ? lbpw_pkg::ONE_Q16 : longint'(fr);
            off = 0;
         end
      endfunction

      function void note_word(logic act, logic [10:0] vidx, logic signed [31:0] px,
                              logic signed [31:0] py);
         longint        cols, rows, bx, by, t, s, xo, yo, stride;
         longint        x1, y1, x2, y2, x3, y3, x4, y4;
         int            i1, i2, i3, i4;
         warp_word_type w;
         if (act == lbpw_pkg::ACT_LOAD) begin
            if (vidx < LAT_DEPTH) begin
               lat_x[vidx] = px; lat_y[vidx] = py;
            end
            return;
         end
         cols = eff_count(cols_r, lbpw_pkg::MAX_COLS_DEF);
         rows = eff_count(rows_r, lbpw_pkg::MAX_ROWS_DEF);
         find_box(px, cols, bw_r, inv_w_r, bx, t, xo);
         find_box(py, rows, bh_r, inv_h_r, by, s, yo);
         stride = cols + 1;
         i1 = int'(by * stride + bx);
         i2 = i1 + 1;
         i3 = int'((by + 1) * stride + bx + 1);
         i4 = i3 - 1;
         x1 = longint'($signed(lat_x[i1])); y1 = longint'($signed(lat_y[i1]));
         x2 = longint'($signed(lat_x[i2])); y2 = longint'($signed(lat_y[i2]));
         x3 = longint'($signed(lat_x[i3])); y3 = longint'($signed(lat_y[i3]));
         x4 = longint'($signed(lat_x[i4])); y4 = longint'($signed(lat_y[i4]));
         w.wx = 32'(sat32(blend(blend(x1, x2, t), blend(x4, x3, t), s) + xo));
         w.wy = 32'(sat32(blend(blend(y1, y4, s), blend(y2, y3, s), t) + yo));
         pending_warps = {pending_warps, w};
      endfunction

      task report(string what, logic signed [31:0] got, logic signed [31:0] want);
         errors++;
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      endtask

      task check_word(logic signed [31:0] wx, logic signed [31:0] wy);
         warp_word_type w;
         if (pending_warps.size() == 0) begin
            report("unexpected word", wx, wy);
            return;
         end
         w = pending_warps.pop_front();
         if (wx !== w.wx) report("warped_x", wx, w.wx);
         if (wy !== w.wy) report("warped_y", wy, w.wy);
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = lbpw_pkg::ACT_LOAD;
   logic [10:0]        req_vertex_index = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_warped_x;
   logic signed [31:0] rsp_warped_y;
   logic               csr_write_en = 1'b0;
   logic [lbpw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   warp_scoreboard sb = new();
   int words_sent = 0;    // drives the idling schedule
   int loaded_prefix = 0; // lattice entries 0..loaded_prefix-1 hold known values

   lattice_bilinear_point_warp DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idling schedule: sender light / receiver heavy, then swapped, then none.
   function automatic int send_idle_pct();
      if (words_sent < 250) return 11;
      if (words_sent < 500) return 45;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (words_sent < 250) return 45;
      if (words_sent < 500) return 11;
      return 0;
   endfunction

   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct());

   // Sample at the falling edge: values are settled for the coming rising edge.
   always @(negedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_warped_x, rsp_warped_y);

   task automatic send_word(logic act, logic [10:0] vidx, logic signed [31:0] px,
                            logic signed [31:0] py);
      bit hs;
      if ($urandom_range(99) < send_idle_pct()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_vertex_index <= vidx;
      req_point_x      <= px;
      req_point_y      <= py;
      do begin
         @(negedge clock);
         hs = req_ready;
         @(posedge clock);
      end while (!hs);
      sb.note_word(act, vidx, px, py);
      words_sent++;
   endtask

   // drop valid right at the accepting edge so the last word is not taken twice
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_warps.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [lbpw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // control point value: mostly moderate, sometimes full range to reach saturation
   function automatic logic signed [31:0] rand_coord();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(3) != 0) v = v >>> $urandom_range(12, 4);
      return v;
   endfunction

   // query point near the rest grid of n boxes of size bw, or anywhere
   function automatic logic signed [31:0] rand_query(longint n, longint bw);
      longint    span, lo, pick;
      bit [63:0] r;
      if ($urandom_range(99) < 15) return $urandom;
      span = n * bw + 2 * bw;
      lo = -((n * bw) >>> 1) - bw;
      r = {$urandom, $urandom};
      pick = lo + longint'(r % 64'(span + 1));
      return 32'(sb.sat32(pick));
   endfunction

   task automatic load_prefix();
      int need;
      need = int'((sb.eff_count(sb.cols_r, lbpw_pkg::MAX_COLS_DEF) + 1)
             * (sb.eff_count(sb.rows_r, lbpw_pkg::MAX_ROWS_DEF) + 1));
      for (int i = loaded_prefix; i < need; i++)
         send_word(lbpw_pkg::ACT_LOAD, 11'(i), rand_coord(), rand_coord());
      if (need > loaded_prefix) loaded_prefix = need;
   endtask

   // One setting: drain, reprogram, fill the lattice in use, then random words.
   task automatic run_phase(logic [31:0] cols, logic [31:0] rows, logic [31:0] bw,
                            logic [31:0] bh, logic [31:0] iw, logic [31:0] ih, int count);
      longint nc, nr;
      int     sel;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);  // loads may still be in flight
      write_reg(lbpw_pkg::CSR_GRID_COLS, cols);
      write_reg(lbpw_pkg::CSR_GRID_ROWS, rows);
      write_reg(lbpw_pkg::CSR_BOX_W, bw);
      write_reg(lbpw_pkg::CSR_BOX_H, bh);
      write_reg(lbpw_pkg::CSR_INV_W, iw);
      write_reg(lbpw_pkg::CSR_INV_H, ih);
      csr_write_en <= 1'b0;
      load_prefix();
      nc = sb.eff_count(sb.cols_r, lbpw_pkg::MAX_COLS_DEF);
      nr = sb.eff_count(sb.rows_r, lbpw_pkg::MAX_ROWS_DEF);
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) wait_drained();
         sel = $urandom_range(99);
         if (sel < 12)
            send_word(lbpw_pkg::ACT_LOAD, 11'($urandom_range(loaded_prefix - 1)),
                      rand_coord(), rand_coord());
         else if (sel < 15)
            send_word(lbpw_pkg::ACT_LOAD, 11'($urandom_range(2047, LAT_DEPTH)),
                      $urandom, $urandom);
         else
            send_word(lbpw_pkg::ACT_WARP, 11'($urandom), rand_query(nc, sb.bw_r),
                      rand_query(nr, sb.bh_r));
      end
   endtask

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset setting, one box from -0.5 to 0.5, centred on zero
      send_word(lbpw_pkg::ACT_LOAD, 11'd0, 32'shFFFF_8000, 32'shFFFF_8000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd1, 32'sh0000_8000, 32'shFFFF_8000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd2, 32'shFFFF_8000, 32'sh0000_8000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd3, 32'sh0000_8000, 32'sh0000_8000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd2047, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF); // beyond
      send_word(lbpw_pkg::ACT_LOAD, 11'd1088, 32'sh1234_5678, -32'sh1234_5678); // last
      loaded_prefix = 4;
      send_word(lbpw_pkg::ACT_WARP, 11'h7FF, 32'sh0, 32'sh0);                 // centre
      send_word(lbpw_pkg::ACT_WARP, 11'h000, 32'shFFFF_8000, 32'shFFFF_8000); // corner
      send_word(lbpw_pkg::ACT_WARP, 11'h555, 32'sh0000_8000, 32'sh0000_8000); // far corner
      send_word(lbpw_pkg::ACT_WARP, 11'h2AA, 32'sh0000_4000, -32'sh0000_2000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);   // far out
      send_word(lbpw_pkg::ACT_WARP, 11'h0, -32'sh8000_0000, -32'sh8000_0000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, 32'sh7FFF_FFFF, -32'sh8000_0000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, 32'sh0000_8001, 32'shFFFF_7FFF);   // just out
      // saturating corners with far-out query
      send_word(lbpw_pkg::ACT_LOAD, 11'd1, 32'sh7FFF_FFFF, -32'sh8000_0000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, 32'sh7FFF_0000, 32'sh7000_0000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, -32'sh7FFF_0000, -32'sh7000_0000);
      send_word(lbpw_pkg::ACT_LOAD, 11'd0, -32'sh8000_0000, -32'sh8000_0000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, -32'sh8000_0000, -32'sh8000_0000);
      send_word(lbpw_pkg::ACT_WARP, 11'h0, 32'sh0000_0001, 32'shFFFF_FFFF);

      run_phase(32, 1, 32'h8000, 32'h10000, 32'h20000, 32'h10000, 60);
      run_phase(1, 32, 32'h10000, 32'h8000, 32'h10000, 32'h20000, 60);
      run_phase(4, 3, 32'h30000, 32'h28000, 32'h5555, 32'h6666, 70);
      run_phase(0, 63, 32'h18000, 32'h4000, 32'hAAAA, 32'h40000, 60);   // counts clamp
      run_phase(5, 5, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 70);
      run_phase(2, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h2, 32'h2, 60);
      run_phase(40, 1, 32'hFFFF_FFFF, 32'h1234, $urandom, $urandom, 50); // masked widths
      run_phase(8, 6, 32'h0002_3456, 32'h0001_9ABC, $urandom, $urandom, 60);
      run_phase(3, 2, 32'h0000_C000, 32'h0005_0000, 32'h1, 32'h1, 50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_warps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
rtl/core/lbpw_pkg.sv
rtl/core/lbpw_ram.sv
rtl/core/lbpw_locate.sv
rtl/core/lbpw_lerp.sv
rtl/core/lattice_bilinear_point_warp.sv
dv/lattice_bilinear_point_warp_test.sv
